// ----- hw/rtl/ptsc_pkg.sv -----
// ptsc_pkg: shared types, constants and helpers of the pressure/temperature compensation block
// depends on nothing; used by every module under hw/rtl
`timescale 1ns / 1ps

package ptsc_pkg;

  localparam int unsigned CFG_W     = 48;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MID = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HI  = 2'd3;

  localparam int unsigned FRONT_LAT = 10;
  localparam int unsigned QDEPTH    = 16;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned POST_LAT  = 7;

  localparam logic signed [63:0] PRESS_MAX = 64'sd33554431;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [24:0]        pressure_q24_8;
    logic               pressure_valid;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] temp_co;
    logic [CFG_W-1:0] press_lo;
    logic [CFG_W-1:0] press_mid;
    logic [CFG_W-1:0] press_hi;
  } coef_t;

  // one queued item: finished temperature, divide operands, nonzero flag
  typedef struct packed {
    logic signed [15:0] temp;
    logic signed [63:0] num;
    logic signed [31:0] den;
    logic               nz;
  } work_t;

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [31:0] sdiv_p2_32(logic signed [31:0] x, int unsigned k);
    logic signed [31:0] bias;
    bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
    return (x + bias) >>> k;
  endfunction

  function automatic logic signed [63:0] sdiv_p2_64(logic signed [63:0] x, int unsigned k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage

// ----- hw/rtl/ptsc_front.sv -----
// ptsc_front: temperature path and pressure divide operands, ten register stages
// depends on ptsc_pkg
`timescale 1ns / 1ps

module ptsc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  ptsc_pkg::in_t    in_i,
  input  ptsc_pkg::coef_t  coef_i,
  output logic             out_valid_o,
  output ptsc_pkg::work_t  out_o
);

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;

  assign t1 = coef_i.temp_co[15:0];
  assign t2 = $signed(coef_i.temp_co[31:16]);
  assign t3 = $signed(coef_i.temp_co[47:32]);
  assign p1 = coef_i.press_lo[15:0];
  assign p2 = $signed(coef_i.press_lo[31:16]);
  assign p3 = $signed(coef_i.press_lo[47:32]);
  assign p4 = $signed(coef_i.press_mid[15:0]);
  assign p5 = $signed(coef_i.press_mid[31:16]);
  assign p6 = $signed(coef_i.press_mid[47:32]);

  logic [ptsc_pkg::FRONT_LAT-1:0] vld_q;
  logic [19:0]        adct_q;
  logic [19:0]        adcp_q [8];
  logic signed [15:0] tmp_q [6];
  logic signed [31:0] ap_q, dd_q, a3_q, bp_q, fine_q;
  logic signed [63:0] v1sq_q, v2a_q, v1a_q, v2_q, y_q, yp_q, v2_8_q, n0_q, num_q;
  logic signed [48:0] v1p5_q, v1p2_q, v1p5_6_q, v1p2_6_q;
  logic signed [31:0] den_q, den10_q;
  logic               nz_q;

  // stage 2
  logic signed [17:0] tx;
  logic signed [16:0] dt;
  logic signed [33:0] ap_full, dd_full;
  assign tx      = $signed({1'b0, adct_q[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign dt      = $signed({1'b0, adct_q[19:4]}) - $signed({1'b0, t1});
  assign ap_full = tx * t2;
  assign dd_full = dt * dt;

  // stage 3
  logic signed [31:0] db;
  logic signed [47:0] bp_full;
  assign db      = ptsc_pkg::sdiv_p2_32(dd_q, 12);
  assign bp_full = db * t3;

  // stage 5
  logic signed [31:0] f5, tq;
  logic signed [15:0] tsat;
  logic signed [32:0] v1;
  logic signed [65:0] v1sq_full;
  logic signed [48:0] v1p5, v1p2;
  assign f5        = fine_q * 32'sd5 + 32'sd128;
  assign tq        = ptsc_pkg::sdiv_p2_32(f5, 8);
  assign tsat      = (tq > 32'sd32767)  ? 16'sh7fff :
                     (tq < -32'sd32768) ? 16'sh8000 : tq[15:0];
  assign v1        = $signed({fine_q[31], fine_q}) - 33'sd128000;
  assign v1sq_full = v1 * v1;
  assign v1p5      = v1 * p5;
  assign v1p2      = v1 * p2;

  // stage 6
  logic signed [63:0] v2a, v1a;
  assign v2a = v1sq_q * p6;
  assign v1a = v1sq_q * p3;

  // stage 7
  logic [63:0] v1p5_x, v1p2_x, term5, term2, term4;
  logic signed [63:0] v2, xs, ys;
  assign v1p5_x = {{15{v1p5_6_q[48]}}, v1p5_6_q};
  assign v1p2_x = {{15{v1p2_6_q[48]}}, v1p2_6_q};
  assign term5  = {v1p5_x[46:0], 17'b0};
  assign term2  = {v1p2_x[51:0], 12'b0};
  assign term4  = {{13{p4[15]}}, p4, 35'b0};
  assign v2     = $signed(v2a_q + term5 + term4);
  assign xs     = ptsc_pkg::sdiv_p2_64(v1a_q, 8) + $signed(term2);
  assign ys     = xs + 64'sh0000_8000_0000_0000;

  // stage 8
  logic signed [63:0] yp;
  assign yp = y_q * $signed({1'b0, p1});

  // stage 9
  logic signed [63:0] den_full, n0;
  logic [20:0]        pp;
  assign den_full = ptsc_pkg::sdiv_p2_64(yp_q, 33);
  assign pp       = 21'h100000 - {1'b0, adcp_q[7]};
  assign n0       = $signed({12'b0, pp, 31'b0}) - v2_8_q;

  // stage 10
  logic signed [63:0] num;
  assign num = n0_q * 64'sd3125;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ptsc_pkg::FRONT_LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    adct_q    <= in_i.raw_temperature;
    adcp_q[0] <= in_i.raw_pressure;
    for (int i = 1; i < 8; i++) begin
      adcp_q[i] <= adcp_q[i-1];
    end
    ap_q     <= ap_full[31:0];
    dd_q     <= dd_full[31:0];
    a3_q     <= ptsc_pkg::sdiv_p2_32(ap_q, 11);
    bp_q     <= bp_full[31:0];
    fine_q   <= a3_q + ptsc_pkg::sdiv_p2_32(bp_q, 14);
    tmp_q[0] <= tsat;
    for (int i = 1; i < 6; i++) begin
      tmp_q[i] <= tmp_q[i-1];
    end
    v1sq_q   <= v1sq_full[63:0];
    v1p5_q   <= v1p5;
    v1p2_q   <= v1p2;
    v2a_q    <= v2a;
    v1a_q    <= v1a;
    v1p5_6_q <= v1p5_q;
    v1p2_6_q <= v1p2_q;
    v2_q     <= v2;
    y_q      <= ys;
    yp_q     <= yp;
    v2_8_q   <= v2_q;
    den_q    <= den_full[31:0];
    n0_q     <= n0;
    num_q    <= num;
    den10_q  <= den_q;
    nz_q     <= (den_q != 32'sd0);
  end

  assign out_valid_o = vld_q[ptsc_pkg::FRONT_LAT-1];
  assign out_o.temp  = tmp_q[5];
  assign out_o.num   = num_q;
  assign out_o.den   = den10_q;
  assign out_o.nz    = nz_q;

endmodule

// ----- hw/rtl/ptsc_queue.sv -----
// ptsc_queue: small item queue between the front and back parts
// depends on ptsc_pkg
`timescale 1ns / 1ps

module ptsc_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  ptsc_pkg::work_t               push_data_i,
  input  logic                          pop_i,
  output ptsc_pkg::work_t               pop_data_o,
  output logic                          empty_o,
  output logic [ptsc_pkg::QCNT_W-1:0]   count_o
);

  ptsc_pkg::work_t                 mem_q [ptsc_pkg::QDEPTH];
  logic [ptsc_pkg::QPTR_W-1:0]     wr_q, rd_q;
  logic [ptsc_pkg::QCNT_W-1:0]     cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_q];
  assign empty_o    = (cnt_q == '0);
  assign count_o    = cnt_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < ptsc_pkg::QCNT_W'(ptsc_pkg::QDEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue pop while empty");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == cnt_q[ptsc_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ----- hw/rtl/ptsc_back.sv -----
// ptsc_back: pipelined 64-step divider and pressure refinement
// depends on ptsc_pkg
`timescale 1ns / 1ps

module ptsc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  ptsc_pkg::work_t  in_i,
  input  ptsc_pkg::coef_t  coef_i,
  output logic             out_valid_o,
  output ptsc_pkg::out_t   out_o
);

  localparam int unsigned N = ptsc_pkg::DIV_STEPS;

  logic signed [15:0] p7, p8, p9;
  assign p7 = $signed(coef_i.press_hi[15:0]);
  assign p8 = $signed(coef_i.press_hi[31:16]);
  assign p9 = $signed(coef_i.press_hi[47:32]);

  // divider stages, index 0 is the entry register
  logic [N:0]         dvld_q;
  logic [31:0]        rem_q  [N+1];
  logic [63:0]        nq_q   [N+1];
  logic [31:0]        dm_q   [N+1];
  logic               qneg_q [N+1];
  logic               nz_q   [N+1];
  logic signed [15:0] tmp_q  [N+1];

  logic [32:0] cand [N];
  logic [33:0] diff [N];
  logic [31:0] rem_d [N];
  logic [63:0] nq_d  [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      cand[i]  = {rem_q[i], nq_q[i][63]};
      diff[i]  = {1'b0, cand[i]} - {2'b0, dm_q[i]};
      rem_d[i] = diff[i][33] ? cand[i][31:0] : diff[i][31:0];
      nq_d[i]  = {nq_q[i][62:0], ~diff[i][33]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= '0;
    end else begin
      dvld_q <= {dvld_q[N-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    nq_q[0]   <= in_i.num[63] ? (64'd0 - in_i.num) : in_i.num;
    dm_q[0]   <= in_i.den[31] ? (32'd0 - in_i.den) : in_i.den;
    qneg_q[0] <= in_i.num[63] ^ in_i.den[31];
    nz_q[0]   <= in_i.nz;
    tmp_q[0]  <= in_i.temp;
    for (int i = 0; i < N; i++) begin
      rem_q[i+1]  <= rem_d[i];
      nq_q[i+1]   <= nq_d[i];
      dm_q[i+1]   <= dm_q[i];
      qneg_q[i+1] <= qneg_q[i];
      nz_q[i+1]   <= nz_q[i];
      tmp_q[i+1]  <= tmp_q[i];
    end
  end

  // refinement stages
  logic [ptsc_pkg::POST_LAT-1:0] pv_q;
  logic signed [15:0] ptmp_q [ptsc_pkg::POST_LAT-1];
  logic               pnz_q  [ptsc_pkg::POST_LAT-1];
  logic signed [63:0] p_q, pa_q, pb_q, pc_q, pe_q, pd_q, pd3_q, m2_q, m1_q;
  logic signed [63:0] v2_q, v24_q, v25_q, v1_q, s_q;
  logic [63:0]        lo_q;
  logic [31:0]        c1_q, c2_q;
  ptsc_pkg::out_t     res_q;

  logic signed [63:0] pd, m2, m1, v2, v1, pr, pq;
  logic [63:0]        lo, mm;
  logic [31:0]        c1, c2;
  logic [24:0]        psat;

  assign pq = qneg_q[N] ? (64'sd0 - $signed(nq_q[N])) : $signed(nq_q[N]);
  assign pd = ptsc_pkg::sdiv_p2_64(p_q, 13);
  assign m2 = p_q * p8;
  assign m1 = pd_q * p9;
  assign v2 = ptsc_pkg::sdiv_p2_64(m2_q, 19);
  assign lo = m1_q[31:0] * pd3_q[31:0];
  assign c1 = m1_q[31:0] * pd3_q[63:32];
  assign c2 = m1_q[63:32] * pd3_q[31:0];
  assign mm = lo_q + {c1_q + c2_q, 32'b0};
  assign v1 = ptsc_pkg::sdiv_p2_64($signed(mm), 25);
  assign pr = ptsc_pkg::sdiv_p2_64(s_q, 8) + $signed({{44{p7[15]}}, p7, 4'b0});

  always_comb begin
    if (pr[63]) begin
      psat = '0;
    end else if (pr > ptsc_pkg::PRESS_MAX) begin
      psat = ptsc_pkg::PRESS_MAX[24:0];
    end else begin
      psat = pr[24:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      pv_q <= {pv_q[ptsc_pkg::POST_LAT-2:0], dvld_q[N]};
    end
  end

  always_ff @(posedge clk_i) begin
    ptmp_q[0] <= tmp_q[N];
    pnz_q[0]  <= nz_q[N];
    for (int i = 1; i < ptsc_pkg::POST_LAT - 1; i++) begin
      ptmp_q[i] <= ptmp_q[i-1];
      pnz_q[i]  <= pnz_q[i-1];
    end
    p_q   <= pq;
    pd_q  <= pd;
    m2_q  <= m2;
    pa_q  <= p_q;
    m1_q  <= m1;
    v2_q  <= v2;
    pd3_q <= pd_q;
    pb_q  <= pa_q;
    lo_q  <= lo;
    c1_q  <= c1;
    c2_q  <= c2;
    v24_q <= v2_q;
    pc_q  <= pb_q;
    v1_q  <= v1;
    v25_q <= v24_q;
    pe_q  <= pc_q;
    s_q   <= pe_q + v1_q + v25_q;
    res_q.temperature_centi <= ptmp_q[ptsc_pkg::POST_LAT-2];
    res_q.pressure_valid    <= pnz_q[ptsc_pkg::POST_LAT-2];
    res_q.pressure_q24_8    <= pnz_q[ptsc_pkg::POST_LAT-2] ? psat : '0;
  end

  assign out_valid_o = pv_q[ptsc_pkg::POST_LAT-1];
  assign out_o       = res_q;

endmodule

// ----- hw/rtl/pressure_temp_sensor_compensation.sv -----
// pressure_temp_sensor_compensation: top level, coefficient registers and part wiring
// depends on ptsc_pkg, ptsc_front, ptsc_queue, ptsc_back
//
//   channel   ports                                   direction  handshake
//   sample    start, busy, in_i                       in         start && !busy
//   result    done_o, res_o                           out        done_o, one cycle
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i        in         cfg_we_i
//
// one sample per cycle while busy is low; each result passes, in order, through
// 10 front stages, 1 queue stage, 1 divider entry stage, 64 divider steps and
// 7 refinement stages
// the divider retires one quotient bit per stage, so latency is fixed
// reset clears the coefficient registers, queue and all stage valid bits
// busy rises only if the queue nears full; the back part takes an item every
// cycle, so the queue holds at most one item and busy stays low
// the receiver cannot stall
`timescale 1ns / 1ps

module pressure_temp_sensor_compensation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  ptsc_pkg::in_t                  in_i,
  output logic                           done_o,
  output ptsc_pkg::out_t                 res_o,
  input  logic                           cfg_we_i,
  input  logic [ptsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ptsc_pkg::CFG_W-1:0]     cfg_wdata_i
);

  ptsc_pkg::coef_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ptsc_pkg::CFG_TEMP:      coef_q.temp_co   <= cfg_wdata_i;
        ptsc_pkg::CFG_PRESS_LO:  coef_q.press_lo  <= cfg_wdata_i;
        ptsc_pkg::CFG_PRESS_MID: coef_q.press_mid <= cfg_wdata_i;
        ptsc_pkg::CFG_PRESS_HI:  coef_q.press_hi  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic                          accept, f_valid, q_empty;
  ptsc_pkg::work_t               f_item, q_item;
  logic [ptsc_pkg::QCNT_W-1:0]   q_count;

  // front items in flight never exceed the headroom left in the queue
  assign busy   = q_count >= ptsc_pkg::QCNT_W'(ptsc_pkg::QDEPTH - ptsc_pkg::FRONT_LAT);
  assign accept = start && !busy;

  ptsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .in_i       (in_i),
    .coef_i     (coef_q),
    .out_valid_o(f_valid),
    .out_o      (f_item)
  );

  ptsc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (f_valid),
    .push_data_i(f_item),
    .pop_i      (!q_empty),
    .pop_data_o (q_item),
    .empty_o    (q_empty),
    .count_o    (q_count)
  );

  ptsc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!q_empty),
    .in_i       (q_item),
    .coef_i     (coef_q),
    .out_valid_o(done_o),
    .out_o      (res_o)
  );

endmodule

// ----- sim/tb.sv -----
// tb: self-checking bench for pressure_temp_sensor_compensation
// depends on ptsc_pkg and the block's rtl; predicts each result with 32/64-bit integer math
`timescale 1ns / 1ps

module tb;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  ptsc_pkg::in_t                  in_i;
  logic                           done_o;
  ptsc_pkg::out_t                 res_o;
  logic                           cfg_we_i;
  logic [ptsc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [ptsc_pkg::CFG_W-1:0]     cfg_wdata_i;

  pressure_temp_sensor_compensation uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .done_o(done_o), .res_o(res_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  ptsc_pkg::coef_t  coefs;
  ptsc_pkg::in_t    samples_todo[$];
  ptsc_pkg::out_t   readings_due[$];
  int     gap_left;
  bit     hold_off;
  bit     no_gaps;
  int     errors;
  int     n_sent;
  int     n_checked;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("timeout at %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

  // signed 64-bit divide truncating toward zero; divide by -1 wraps
  function automatic longint quot64(longint a, longint b);
    if (b == -64'sd1) return -a;
    return a / b;
  endfunction

  function automatic ptsc_pkg::out_t compensate(ptsc_pkg::in_t s);
    int     adc_p, adc_t, t1, t2, t3, a, b, d, fine, temp;
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
    ptsc_pkg::out_t r;
    adc_p = int'({12'd0, s.raw_pressure});
    adc_t = int'({12'd0, s.raw_temperature});
    t1 = int'({16'd0, coefs.temp_co[15:0]});
    t2 = int'($signed(coefs.temp_co[31:16]));
    t3 = int'($signed(coefs.temp_co[47:32]));
    p1 = longint'({48'd0, coefs.press_lo[15:0]});
    p2 = longint'($signed(coefs.press_lo[31:16]));
    p3 = longint'($signed(coefs.press_lo[47:32]));
    p4 = longint'($signed(coefs.press_mid[15:0]));
    p5 = longint'($signed(coefs.press_mid[31:16]));
    p6 = longint'($signed(coefs.press_mid[47:32]));
    p7 = longint'($signed(coefs.press_hi[15:0]));
    p8 = longint'($signed(coefs.press_hi[31:16]));
    p9 = longint'($signed(coefs.press_hi[47:32]));

    a = ((adc_t / 8 - t1 * 2) * t2) / 2048;
    d = adc_t / 16 - t1;
    b = (((d * d) / 4096) * t3) / 16384;
    fine = a + b;
    temp = (fine * 5 + 128) / 256;
    if (temp > 32767) temp = 32767;
    if (temp < -32768) temp = -32768;

    v1 = longint'(fine) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + v1 * p5 * 64'sd131072;
    v2 = v2 + p4 * 64'sd34359738368;
    v1 = quot64(v1 * v1 * p3, 64'sd256) + v1 * p2 * 64'sd4096;
    v1 = quot64((64'sd140737488355328 + v1) * p1, 64'sd8589934592);

    r.temperature_centi = temp[15:0];
    r.pressure_q24_8 = '0;
    r.pressure_valid = 1'b0;
    if (v1 != 0) begin
      p = 64'sd1048576 - longint'(adc_p);
      p = quot64((p * 64'sd2147483648 - v2) * 64'sd3125, v1);
      v1 = quot64(p9 * (p / 64'sd8192) * (p / 64'sd8192), 64'sd33554432);
      v2 = quot64(p8 * p, 64'sd524288);
      p = quot64(p + v1 + v2, 64'sd256) + p7 * 64'sd16;
      if (p < 0) p = 0;
      if (p > ptsc_pkg::PRESS_MAX) p = ptsc_pkg::PRESS_MAX;
      r.pressure_q24_8 = p[24:0];
      r.pressure_valid = 1'b1;
    end
    return r;
  endfunction

  // driver: one item per handshake, random gap drawn per item unless no_gaps is set
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      in_i     <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        readings_due.push_back(compensate(in_i));
        n_sent++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (!hold_off && samples_todo.size() > 0) begin
        in_i     <= samples_todo.pop_front();
        start    <= 1'b1;
        gap_left <= no_gaps ? 0 : int'($urandom_range(0, 4));
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be held off, check each on its strobe
  always @(posedge clk_i) begin
    ptsc_pkg::out_t want;
    if (rst_ni && done_o) begin
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_o);
        errors++;
      end else begin
        want = readings_due.pop_front();
        n_checked++;
        if (res_o.temperature_centi !== want.temperature_centi) begin
          $display("%0t: temperature_centi expected %0d got %0d", $time,
                   want.temperature_centi, res_o.temperature_centi);
          errors++;
        end
        if (res_o.pressure_q24_8 !== want.pressure_q24_8) begin
          $display("%0t: pressure_q24_8 expected %0d got %0d", $time,
                   want.pressure_q24_8, res_o.pressure_q24_8);
          errors++;
        end
        if (res_o.pressure_valid !== want.pressure_valid) begin
          $display("%0t: pressure_valid expected %0d got %0d", $time,
                   want.pressure_valid, res_o.pressure_valid);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [ptsc_pkg::CFG_IDX_W-1:0] idx,
                           logic [ptsc_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      ptsc_pkg::CFG_TEMP:      coefs.temp_co   = val;
      ptsc_pkg::CFG_PRESS_LO:  coefs.press_lo  = val;
      ptsc_pkg::CFG_PRESS_MID: coefs.press_mid = val;
      default:                 coefs.press_hi  = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_coefs(logic [ptsc_pkg::CFG_W-1:0] tc, logic [ptsc_pkg::CFG_W-1:0] pl,
                            logic [ptsc_pkg::CFG_W-1:0] pm, logic [ptsc_pkg::CFG_W-1:0] ph);
    write_reg(ptsc_pkg::CFG_TEMP, tc);
    write_reg(ptsc_pkg::CFG_PRESS_LO, pl);
    write_reg(ptsc_pkg::CFG_PRESS_MID, pm);
    write_reg(ptsc_pkg::CFG_PRESS_HI, ph);
  endtask

  task automatic drain();
    while (samples_todo.size() > 0 || start || readings_due.size() > 0) @(posedge clk_i);
    repeat (ptsc_pkg::FRONT_LAT + ptsc_pkg::DIV_STEPS + ptsc_pkg::POST_LAT + 10)
      @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  // raw readings from a typical band plus random wobble so the pressure path stays mostly in range
  function automatic ptsc_pkg::in_t near_typical();
    ptsc_pkg::in_t s;
    s.raw_pressure    = 20'($urandom_range(300000, 650000));
    s.raw_temperature = 20'($urandom_range(380000, 620000));
    return s;
  endfunction

  function automatic ptsc_pkg::in_t any_sample();
    ptsc_pkg::in_t s;
    s.raw_pressure    = 20'($urandom_range(0, 20'hFFFFF));
    s.raw_temperature = 20'($urandom_range(0, 20'hFFFFF));
    return s;
  endfunction

  localparam logic [47:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [47:0] TYP_PL = {16'd3024, 16'hD643, 16'd36477};
  localparam logic [47:0] TYP_PM = {16'hFFF9, 16'd140, 16'd2855};
  localparam logic [47:0] TYP_PH = {16'd6000, 16'hC6F8, 16'd15500};

  initial begin
    ptsc_pkg::in_t s;
    errors = 0; n_sent = 0; n_checked = 0;
    hold_off = 1'b0; no_gaps = 1'b0;
    coefs = '0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients: zero denominator, pressure flagged invalid
    s = '0; samples_todo.push_back(s);
    s = '1; samples_todo.push_back(s);
    drain();

    // directed extremes with typical trims
    load_coefs(TYP_T, TYP_PL, TYP_PM, TYP_PH);
    s = '0;                                        samples_todo.push_back(s);
    s = '1;                                        samples_todo.push_back(s);
    s.raw_pressure = 20'hFFFFF; s.raw_temperature = 0; samples_todo.push_back(s);
    s.raw_pressure = 0; s.raw_temperature = 20'hFFFFF; samples_todo.push_back(s);
    s.raw_pressure = 20'd415148; s.raw_temperature = 20'd519888; samples_todo.push_back(s);
    s.raw_pressure = 20'h80000; s.raw_temperature = 20'h7FFFF; samples_todo.push_back(s);
    drain();

    // extreme trims: saturation and wrapping paths
    load_coefs('1, '1, '1, '1);
    s = '0; samples_todo.push_back(s);
    s = '1; samples_todo.push_back(s);
    drain();
    load_coefs({3{16'h8000}}, {16'h8000, 16'h8000, 16'hFFFF}, {3{16'h8000}}, {3{16'h8000}});
    s = '0; samples_todo.push_back(s);
    s = '1; samples_todo.push_back(s);
    drain();
    load_coefs({3{16'h7FFF}}, {16'h7FFF, 16'h7FFF, 16'h0001}, {3{16'h7FFF}}, {3{16'h7FFF}});
    s = '0; samples_todo.push_back(s);
    s = '1; samples_todo.push_back(s);
    s.raw_pressure = 20'hFFFFF; s.raw_temperature = 0; samples_todo.push_back(s);
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) load_coefs(TYP_T ^ (rand48() & 48'h00FF00FF00FF),
                             TYP_PL ^ (rand48() & 48'h00FF00FF00FF),
                             TYP_PM ^ (rand48() & 48'h000F000F00FF),
                             TYP_PH ^ (rand48() & 48'h00FF00FF00FF));
      else if (ph == 7) load_coefs('0, rand48(), rand48(), rand48());
      else load_coefs(rand48(), rand48(), rand48(), rand48());
      no_gaps = (ph % 3 == 1);
      for (int k = 0; k < 200; k++) begin
        samples_todo.push_back(($urandom_range(0, 3) == 0) ? any_sample() : near_typical());
        if (ph == 2 && k == 100) begin
          // let the pipe empty completely before sending more
          while (samples_todo.size() > 0) @(posedge clk_i);
          hold_off = 1'b1;
          while (start || readings_due.size() > 0) @(posedge clk_i);
          hold_off = 1'b0;
        end
      end
      drain();
    end

    $display("sent %0d samples over 13 trim settings, %0d results checked", n_sent, n_checked);
    $display("covered reset trims, saturating extremes and random trims with and without gaps");
    if (errors == 0 && readings_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
